@@ design/crgi_pkg.sv @@
// ----------------------------------------------------------------------------
// crgi_pkg
// Shared types, constants and rotation helpers for the cube rotation and
// integer grid isomorphism unit.
// ----------------------------------------------------------------------------
package crgi_pkg;

  localparam int COORD_BITS = 16;
  localparam int ROT_BITS   = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   vec_t;
  typedef logic signed [COORD_BITS+1:0] sum_t;

  localparam sum_t COORD_MAX = sum_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam sum_t COORD_MIN = sum_t'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef enum logic [1:0] {
    OP_COMPOSE = 2'd0,
    OP_INVERT  = 2'd1,
    OP_POINT   = 2'd2,
    OP_VECTOR  = 2'd3
  } opcode_e;

  localparam logic [1:0] AXIS_BAD = 2'd3;

  // Column j of the matrix is the signed unit vector along axis[j].
  typedef struct packed {
    logic [2:0][1:0] axis;
    logic [2:0]      neg;
  } rot_t;

  typedef struct packed {
    rot_t                apply_rot;
    logic [ROT_BITS-1:0] rot_out;
    logic                index_error;
    logic                negate_a;
    logic                add_a;
  } ctrl_t;

  function automatic logic [1:0] next_axis(logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  function automatic rot_t rot_from_index(logic [ROT_BITS-1:0] idx);
    rot_t       r;
    logic [1:0] p;
    logic [1:0] q;
    p = idx[4:3];
    if (p == AXIS_BAD) begin
      p = 2'd0;
    end
    q = idx[1] ? next_axis(next_axis(p)) : next_axis(p);
    r.axis[0] = p;
    r.neg[0]  = idx[2];
    r.axis[1] = q;
    r.neg[1]  = idx[0];
    r.axis[2] = 2'd3 - p - q;
    r.neg[2]  = idx[2] ^ idx[0] ^ idx[1];
    return r;
  endfunction

  function automatic logic [ROT_BITS-1:0] rot_to_index(rot_t r);
    logic sel;
    sel = (r.axis[1] != next_axis(r.axis[0]));
    return {r.axis[0], r.neg[0], sel, r.neg[1]};
  endfunction

  function automatic rot_t rot_mul(rot_t a, rot_t b);
    rot_t c;
    c = '0;
    for (int j = 0; j < 3; j++) begin
      c.axis[j] = a.axis[b.axis[j]];
      c.neg[j]  = a.neg[b.axis[j]] ^ b.neg[j];
    end
    return c;
  endfunction

  function automatic rot_t rot_inv(rot_t a);
    rot_t c;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      c.axis[a.axis[k]] = 2'(k);
      c.neg[a.axis[k]]  = a.neg[k];
    end
    return c;
  endfunction

endpackage

@@ design/crgi_rot_unit.sv @@
// ----------------------------------------------------------------------------
// crgi_rot_unit
// Decodes the rotation indexes, forms the product or inverse rotation and
// selects the rotation and operand controls for the coordinate datapath.
// ----------------------------------------------------------------------------
module crgi_rot_unit (
  input  logic [1:0]                    opcode_i,
  input  logic [crgi_pkg::ROT_BITS-1:0] rot_a_i,
  input  logic [crgi_pkg::ROT_BITS-1:0] rot_b_i,
  output crgi_pkg::ctrl_t               ctrl_o
);

  crgi_pkg::rot_t    rot_a;
  crgi_pkg::rot_t    rot_b;
  crgi_pkg::rot_t    rot_inv_a;
  crgi_pkg::opcode_e op;

  assign op        = crgi_pkg::opcode_e'(opcode_i);
  assign rot_a     = crgi_pkg::rot_from_index(rot_a_i);
  assign rot_b     = crgi_pkg::rot_from_index(rot_b_i);
  assign rot_inv_a = crgi_pkg::rot_inv(rot_a);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.apply_rot = rot_a;
    ctrl_o.rot_out   = rot_a_i;
    unique case (op)
      crgi_pkg::OP_COMPOSE: begin
        ctrl_o.rot_out     = crgi_pkg::rot_to_index(crgi_pkg::rot_mul(rot_a, rot_b));
        ctrl_o.add_a       = 1'b1;
        ctrl_o.index_error = (rot_a_i[4:3] == crgi_pkg::AXIS_BAD) ||
                             (rot_b_i[4:3] == crgi_pkg::AXIS_BAD);
      end
      crgi_pkg::OP_INVERT: begin
        ctrl_o.apply_rot   = rot_inv_a;
        ctrl_o.rot_out     = crgi_pkg::rot_to_index(rot_inv_a);
        ctrl_o.negate_a    = 1'b1;
        ctrl_o.index_error = (rot_a_i[4:3] == crgi_pkg::AXIS_BAD);
      end
      crgi_pkg::OP_POINT: begin
        ctrl_o.add_a       = 1'b1;
        ctrl_o.index_error = (rot_a_i[4:3] == crgi_pkg::AXIS_BAD);
      end
      crgi_pkg::OP_VECTOR: begin
        ctrl_o.index_error = (rot_a_i[4:3] == crgi_pkg::AXIS_BAD);
      end
      default: begin
        ctrl_o.index_error = 1'b1;
      end
    endcase
  end

endmodule

@@ design/crgi_coord_unit.sv @@
// ----------------------------------------------------------------------------
// crgi_coord_unit
// Applies the selected signed axis permutation to a vector, adds the
// translation when asked and clamps each coordinate to the signed range.
// ----------------------------------------------------------------------------
module crgi_coord_unit (
  input  crgi_pkg::ctrl_t ctrl_i,
  input  crgi_pkg::coord_t ax_i,
  input  crgi_pkg::coord_t ay_i,
  input  crgi_pkg::coord_t az_i,
  input  crgi_pkg::coord_t bx_i,
  input  crgi_pkg::coord_t by_i,
  input  crgi_pkg::coord_t bz_i,
  output crgi_pkg::coord_t out_x_o,
  output crgi_pkg::coord_t out_y_o,
  output crgi_pkg::coord_t out_z_o,
  output logic             saturated_o
);

  crgi_pkg::coord_t a   [3];
  crgi_pkg::coord_t b   [3];
  crgi_pkg::vec_t   v   [3];
  crgi_pkg::vec_t   rot [3];
  crgi_pkg::sum_t   sum [3];
  crgi_pkg::coord_t res [3];
  logic [2:0]       sat;

  assign a[0] = ax_i;
  assign a[1] = ay_i;
  assign a[2] = az_i;
  assign b[0] = bx_i;
  assign b[1] = by_i;
  assign b[2] = bz_i;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      v[j]   = ctrl_i.negate_a ? -crgi_pkg::vec_t'(a[j]) : crgi_pkg::vec_t'(b[j]);
      rot[j] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      rot[ctrl_i.apply_rot.axis[j]] = ctrl_i.apply_rot.neg[j] ? -v[j] : v[j];
    end
    for (int i = 0; i < 3; i++) begin
      sum[i] = crgi_pkg::sum_t'(rot[i]) +
               (ctrl_i.add_a ? crgi_pkg::sum_t'(a[i]) : crgi_pkg::sum_t'(0));
      sat[i] = 1'b1;
      if (sum[i] > crgi_pkg::COORD_MAX) begin
        res[i] = crgi_pkg::coord_t'(crgi_pkg::COORD_MAX);
      end else if (sum[i] < crgi_pkg::COORD_MIN) begin
        res[i] = crgi_pkg::coord_t'(crgi_pkg::COORD_MIN);
      end else begin
        res[i] = crgi_pkg::coord_t'(sum[i]);
        sat[i] = 1'b0;
      end
    end
  end

  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign saturated_o = |sat;

endmodule

@@ design/cube_rotation_grid_isomorphism_unit.sv @@
// ----------------------------------------------------------------------------
// cube_rotation_grid_isomorphism_unit
// Composes, inverts and applies integer grid isomorphisms built from the 24
// cube rotations and an integer translation.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries an opcode, rotation indexes and two
// coordinate triples; each one produces exactly one output transfer with the
// resulting rotation index, three clamped coordinates and two status flags.
// The input transfer is captured in an input register; the rotation decode
// and coordinate arithmetic run combinationally on it and land in the
// output register. One item is taken every cycle unless the output is
// stalled (throughput 1 per cycle), set by the single combinational pass
// between the two registers.
// When the receiver holds out_stall_i, the output register keeps its
// result and the input register absorbs one more item; in_stall_o rises
// only when both registers are full and the output is stalled.
// Reset empties both registers; no results are pending after reset.
// ----------------------------------------------------------------------------
module cube_rotation_grid_isomorphism_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [crgi_pkg::ROT_BITS-1:0] rot_a_i,
  input  crgi_pkg::coord_t              ax_i,
  input  crgi_pkg::coord_t              ay_i,
  input  crgi_pkg::coord_t              az_i,
  input  logic [crgi_pkg::ROT_BITS-1:0] rot_b_i,
  input  crgi_pkg::coord_t              bx_i,
  input  crgi_pkg::coord_t              by_i,
  input  crgi_pkg::coord_t              bz_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [crgi_pkg::ROT_BITS-1:0] rot_out_o,
  output crgi_pkg::coord_t              out_x_o,
  output crgi_pkg::coord_t              out_y_o,
  output crgi_pkg::coord_t              out_z_o,
  output logic                          index_error_o,
  output logic                          saturated_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic [1:0]                    opcode_q;
  logic [crgi_pkg::ROT_BITS-1:0] rot_a_q, rot_b_q;
  crgi_pkg::coord_t              ax_q, ay_q, az_q, bx_q, by_q, bz_q;

  logic                          out_valid_q, out_valid_d;
  logic [crgi_pkg::ROT_BITS-1:0] rot_out_q;
  crgi_pkg::coord_t              out_x_q, out_y_q, out_z_q;
  logic                          index_error_q, saturated_q;

  logic                          s2_load;
  logic                          s1_load;
  crgi_pkg::ctrl_t               ctrl;
  crgi_pkg::coord_t              cx, cy, cz;
  logic                          csat;

  assign s2_load     = !out_valid_q || !out_stall_i;
  assign s1_load     = !s1_valid_q || s2_load;
  assign in_stall_o  = !s1_load;
  assign s1_valid_d  = s1_load ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_load ? s1_valid_q : out_valid_q;

  crgi_rot_unit u_rot (
    .opcode_i (opcode_q),
    .rot_a_i  (rot_a_q),
    .rot_b_i  (rot_b_q),
    .ctrl_o   (ctrl)
  );

  crgi_coord_unit u_coord (
    .ctrl_i      (ctrl),
    .ax_i        (ax_q),
    .ay_i        (ay_q),
    .az_i        (az_q),
    .bx_i        (bx_q),
    .by_i        (by_q),
    .bz_i        (bz_q),
    .out_x_o     (cx),
    .out_y_o     (cy),
    .out_z_o     (cz),
    .saturated_o (csat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_load) begin
      opcode_q <= opcode_i;
      rot_a_q  <= rot_a_i;
      rot_b_q  <= rot_b_i;
      ax_q     <= ax_i;
      ay_q     <= ay_i;
      az_q     <= az_i;
      bx_q     <= bx_i;
      by_q     <= by_i;
      bz_q     <= bz_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_load) begin
      if (ctrl.index_error) begin
        rot_out_q     <= '0;
        out_x_q       <= '0;
        out_y_q       <= '0;
        out_z_q       <= '0;
        index_error_q <= 1'b1;
        saturated_q   <= 1'b0;
      end else begin
        rot_out_q     <= ctrl.rot_out;
        out_x_q       <= cx;
        out_y_q       <= cy;
        out_z_q       <= cz;
        index_error_q <= 1'b0;
        saturated_q   <= csat;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rot_out_o     = rot_out_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign index_error_o = index_error_q;
  assign saturated_o   = saturated_q;

  // An index error result carries all-zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && index_error_q |-> rot_out_q == '0 && out_x_q == '0 &&
      out_y_q == '0 && out_z_q == '0 && !saturated_q)
    else $error("index error result carries nonzero data");

  // A good result always names one of the 24 rotations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !index_error_q |-> rot_out_q[4:3] != crgi_pkg::AXIS_BAD)
    else $error("result rotation index out of range");

  // Input stalls only while both the input and the output register hold an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free capacity");

  // An item moving out of the input register shows up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_load |=> out_valid_q)
    else $error("item lost between stages");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cube rotation and integer grid isomorphism unit.
// A short table of directed transfers is followed by random traffic that is
// mostly valid indexes. Both sides idle at random. Accepted transfers without a
// typed table result go through a local predictor of the rotation algebra.
// Each output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_GAP      = 18;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LAST_ROT     = 23;

  localparam crgi_pkg::coord_t C_MAX = crgi_pkg::coord_t'(crgi_pkg::COORD_MAX);
  localparam crgi_pkg::coord_t C_MIN = crgi_pkg::coord_t'(crgi_pkg::COORD_MIN);

  typedef struct {
    crgi_pkg::opcode_e             op;
    logic [crgi_pkg::ROT_BITS-1:0] rot_a;
    crgi_pkg::coord_t              ax;
    crgi_pkg::coord_t              ay;
    crgi_pkg::coord_t              az;
    logic [crgi_pkg::ROT_BITS-1:0] rot_b;
    crgi_pkg::coord_t              bx;
    crgi_pkg::coord_t              by;
    crgi_pkg::coord_t              bz;
  } iso_req_t;

  typedef struct {
    logic [crgi_pkg::ROT_BITS-1:0] rot;
    crgi_pkg::coord_t              x;
    crgi_pkg::coord_t              y;
    crgi_pkg::coord_t              z;
    logic                          index_error;
    logic                          saturated;
  } iso_res_t;

  typedef struct {
    iso_req_t req;
    bit       typed;
    iso_res_t res;
  } table_row_t;

  typedef struct packed {
    logic [2:0][1:0] col_axis;
    logic [2:0]      col_neg;
  } cube_rot_t;

  typedef longint triple_t [3];

  logic                          clk       = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [1:0]                    opcode    = '0;
  logic [crgi_pkg::ROT_BITS-1:0] rot_a     = '0;
  crgi_pkg::coord_t              ax        = '0;
  crgi_pkg::coord_t              ay        = '0;
  crgi_pkg::coord_t              az        = '0;
  logic [crgi_pkg::ROT_BITS-1:0] rot_b     = '0;
  crgi_pkg::coord_t              bx        = '0;
  crgi_pkg::coord_t              by        = '0;
  crgi_pkg::coord_t              bz        = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [crgi_pkg::ROT_BITS-1:0] rot_out;
  crgi_pkg::coord_t              out_x;
  crgi_pkg::coord_t              out_y;
  crgi_pkg::coord_t              out_z;
  logic                          index_error;
  logic                          saturated;

  bit       row_typed = 1'b0;
  iso_res_t row_res;
  iso_res_t no_res;

  iso_res_t   pending_results[$];
  table_row_t directed_rows[$];

  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int results_taken  = 0;
  int index_errs     = 0;
  int saturations    = 0;
  int stalled_cycles = 0;
  int cycle_count    = 0;

  cube_rotation_grid_isomorphism_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .rot_a_i       (rot_a),
    .ax_i          (ax),
    .ay_i          (ay),
    .az_i          (az),
    .rot_b_i       (rot_b),
    .bx_i          (bx),
    .by_i          (by),
    .bz_i          (bz),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .rot_out_o     (rot_out),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_z_o       (out_z),
    .index_error_o (index_error),
    .saturated_o   (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cube_rot_t decode_rot(logic [crgi_pkg::ROT_BITS-1:0] idx);
    cube_rot_t r;
    int        p;
    int        q;
    p = int'(idx[4:3]);
    if (p > 2) begin
      p = 0;
    end
    q = idx[1] ? (p + 2) % 3 : (p + 1) % 3;
    r.col_axis[0] = 2'(p);
    r.col_neg[0]  = idx[2];
    r.col_axis[1] = 2'(q);
    r.col_neg[1]  = idx[0];
    r.col_axis[2] = 2'(3 - p - q);
    r.col_neg[2]  = idx[2] ^ idx[0] ^ idx[1];
    return r;
  endfunction

  function automatic logic [crgi_pkg::ROT_BITS-1:0] encode_rot(cube_rot_t r);
    logic sel;
    sel = (int'(r.col_axis[1]) != (int'(r.col_axis[0]) + 1) % 3);
    return {r.col_axis[0], r.col_neg[0], sel, r.col_neg[1]};
  endfunction

  function automatic cube_rot_t chain_rot(cube_rot_t a, cube_rot_t b);
    cube_rot_t c;
    int        k;
    c = '0;
    for (int j = 0; j < 3; j++) begin
      k = int'(b.col_axis[j]);
      c.col_axis[j] = a.col_axis[k];
      c.col_neg[j]  = a.col_neg[k] ^ b.col_neg[j];
    end
    return c;
  endfunction

  function automatic cube_rot_t reverse_rot(cube_rot_t a);
    cube_rot_t c;
    int        i;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      i = int'(a.col_axis[k]);
      c.col_axis[i] = 2'(k);
      c.col_neg[i]  = a.col_neg[k];
    end
    return c;
  endfunction

  function automatic void rotate_vec(input cube_rot_t r, input triple_t v, output triple_t o);
    for (int j = 0; j < 3; j++) begin
      o[int'(r.col_axis[j])] = r.col_neg[j] ? -v[j] : v[j];
    end
  endfunction

  function automatic crgi_pkg::coord_t clamp_coord(longint v, inout bit sat);
    if (v > longint'(C_MAX)) begin
      sat = 1'b1;
      return C_MAX;
    end
    if (v < longint'(C_MIN)) begin
      sat = 1'b1;
      return C_MIN;
    end
    return crgi_pkg::coord_t'(v);
  endfunction

  function automatic iso_res_t isometry_result(iso_req_t q);
    iso_res_t  res;
    cube_rot_t ra;
    cube_rot_t rinv;
    triple_t   ta;
    triple_t   tb;
    triple_t   w;
    triple_t   o;
    bit        sat;
    sat   = 1'b0;
    ta[0] = longint'(q.ax);
    ta[1] = longint'(q.ay);
    ta[2] = longint'(q.az);
    tb[0] = longint'(q.bx);
    tb[1] = longint'(q.by);
    tb[2] = longint'(q.bz);
    res.rot         = '0;
    res.x           = '0;
    res.y           = '0;
    res.z           = '0;
    res.index_error = 1'b1;
    res.saturated   = 1'b0;
    if (q.rot_a > LAST_ROT ||
        (q.op == crgi_pkg::OP_COMPOSE && q.rot_b > LAST_ROT)) begin
      return res;
    end
    ra      = decode_rot(q.rot_a);
    res.rot = q.rot_a;
    case (q.op)
      crgi_pkg::OP_COMPOSE: begin
        res.rot = encode_rot(chain_rot(ra, decode_rot(q.rot_b)));
        rotate_vec(ra, tb, o);
        for (int j = 0; j < 3; j++) o[j] += ta[j];
      end
      crgi_pkg::OP_INVERT: begin
        rinv    = reverse_rot(ra);
        res.rot = encode_rot(rinv);
        for (int j = 0; j < 3; j++) w[j] = -ta[j];
        rotate_vec(rinv, w, o);
      end
      crgi_pkg::OP_POINT: begin
        rotate_vec(ra, tb, o);
        for (int j = 0; j < 3; j++) o[j] += ta[j];
      end
      default: begin
        rotate_vec(ra, tb, o);
      end
    endcase
    res.x           = clamp_coord(o[0], sat);
    res.y           = clamp_coord(o[1], sat);
    res.z           = clamp_coord(o[2], sat);
    res.index_error = 1'b0;
    res.saturated   = sat;
    return res;
  endfunction

  function automatic iso_req_t make_req(crgi_pkg::opcode_e op, int ra, int vax, int vay,
                                        int vaz, int rb, int vbx, int vby, int vbz);
    iso_req_t q;
    q.op    = op;
    q.rot_a = crgi_pkg::ROT_BITS'(ra);
    q.ax    = crgi_pkg::coord_t'(vax);
    q.ay    = crgi_pkg::coord_t'(vay);
    q.az    = crgi_pkg::coord_t'(vaz);
    q.rot_b = crgi_pkg::ROT_BITS'(rb);
    q.bx    = crgi_pkg::coord_t'(vbx);
    q.by    = crgi_pkg::coord_t'(vby);
    q.bz    = crgi_pkg::coord_t'(vbz);
    return q;
  endfunction

  function automatic iso_res_t make_res(int rot, int vx, int vy, int vz, bit ie, bit sat);
    iso_res_t r;
    r.rot         = crgi_pkg::ROT_BITS'(rot);
    r.x           = crgi_pkg::coord_t'(vx);
    r.y           = crgi_pkg::coord_t'(vy);
    r.z           = crgi_pkg::coord_t'(vz);
    r.index_error = ie;
    r.saturated   = sat;
    return r;
  endfunction

  function automatic logic [crgi_pkg::ROT_BITS-1:0] rand_rot();
    if ($urandom_range(0, 9) == 0) begin
      return crgi_pkg::ROT_BITS'($urandom_range(LAST_ROT + 1, 31));
    end
    return crgi_pkg::ROT_BITS'($urandom_range(0, LAST_ROT));
  endfunction

  function automatic crgi_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return crgi_pkg::coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return crgi_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic iso_req_t rand_req();
    iso_req_t q;
    q.op    = crgi_pkg::opcode_e'($urandom_range(0, 3));
    q.rot_a = rand_rot();
    q.ax    = rand_coord();
    q.ay    = rand_coord();
    q.az    = rand_coord();
    q.rot_b = rand_rot();
    q.bx    = rand_coord();
    q.by    = rand_coord();
    q.bz    = rand_coord();
    return q;
  endfunction

  function automatic void add_row(iso_req_t q, bit typed, iso_res_t r);
    table_row_t row;
    row.req   = q;
    row.typed = typed;
    row.res   = r;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(string name, logic signed [63:0] exp_v,
                             logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic send_item(iso_req_t q, bit typed, iso_res_t r, int gap, bit drain_first);
    if (drain_first && gap == 0) begin
      gap = 1;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && pending_results.size() != 0) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= q.op;
    rot_a     <= q.rot_a;
    ax        <= q.ax;
    ay        <= q.ay;
    az        <= q.az;
    rot_b     <= q.rot_b;
    bx        <= q.bx;
    by        <= q.by;
    bz        <= q.bz;
    row_typed <= typed;
    row_res   <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    iso_req_t q;
    iso_res_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected output transfer, rot %0d x %0d y %0d z %0d",
                   $time, rot_out, out_x, out_y, out_z);
        end else begin
          e = pending_results.pop_front();
          check_field("rot_out", e.rot, rot_out);
          check_field("out_x", e.x, out_x);
          check_field("out_y", e.y, out_y);
          check_field("out_z", e.z, out_z);
          check_field("index_error", e.index_error, index_error);
          check_field("saturated", e.saturated, saturated);
          results_seen++;
        end
        if (index_error === 1'b1) index_errs++;
        if (saturated === 1'b1) saturations++;
      end
      if (in_valid && in_stall) begin
        stalled_cycles++;
      end
      if (in_valid && !in_stall) begin
        q = make_req(crgi_pkg::opcode_e'(opcode), rot_a, ax, ay, az, rot_b, bx, by, bz);
        pending_results.push_back(row_typed ? row_res : isometry_result(q));
      end
    end
  end

  initial begin
    int n;
    do @(posedge clk); while (!rst_ni);
    forever begin
      if (results_taken == HOLD_AT) begin
        n = HOLD_CYCLES;
      end else if (results_taken >= 600 && results_taken < 700) begin
        n = 0;
      end else begin
        n = $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin
    int gap;
    iso_res_t bad;
    bad = make_res(0, 0, 0, 0, 1'b1, 1'b0);

    add_row(make_req(crgi_pkg::OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_res(0, 0, 0, 0, 0, 0));
    add_row(make_req(crgi_pkg::OP_COMPOSE, 23, 1, -2, 3, 23, -4, 5, -6), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_COMPOSE, 0, 7, 7, 7, 24, 1, 1, 1), 1'b1, bad);
    add_row(make_req(crgi_pkg::OP_COMPOSE, 31, 7, 7, 7, 0, 1, 1, 1), 1'b1, bad);
    add_row(make_req(crgi_pkg::OP_INVERT, 24, 5, 5, 5, 0, 0, 0, 0), 1'b1, bad);
    add_row(make_req(crgi_pkg::OP_INVERT, 5, 100, -200, 300, 31, 0, 0, 0), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_POINT, 30, 1, 2, 3, 0, 4, 5, 6), 1'b1, bad);
    add_row(make_req(crgi_pkg::OP_VECTOR, 25, 1, 2, 3, 31, 4, 5, 6), 1'b1, bad);
    add_row(make_req(crgi_pkg::OP_POINT, 0, 1, 1, 1, 31, 32767, 32767, 32767), 1'b1,
            make_res(0, 32767, 32767, 32767, 0, 1));
    add_row(make_req(crgi_pkg::OP_POINT, 0, -1, -1, -1, 0, -32768, -32768, -32768), 1'b1,
            make_res(0, -32768, -32768, -32768, 0, 1));
    add_row(make_req(crgi_pkg::OP_VECTOR, 0, 9, 9, 9, 0, -32768, 32767, 0), 1'b1,
            make_res(0, -32768, 32767, 0, 0, 0));
    add_row(make_req(crgi_pkg::OP_INVERT, 0, -32768, -32768, -32768, 0, 0, 0, 0), 1'b1,
            make_res(0, 32767, 32767, 32767, 0, 1));
    add_row(make_req(crgi_pkg::OP_INVERT, 0, 32767, -32767, 0, 0, 0, 0, 0), 1'b1,
            make_res(0, -32767, 32767, 0, 0, 0));
    add_row(make_req(crgi_pkg::OP_VECTOR, 4, 0, 0, 0, 0, -32768, -32768, -32768),
            1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_VECTOR, 23, 0, 0, 0, 0, -32768, -32768, -32768),
            1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_COMPOSE, 7, 32767, 32767, 32767, 16, 32767, 32767,
                     32767), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_COMPOSE, 12, -32768, -32768, -32768, 9, -32768, -32768,
                     -32768), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_POINT, 15, 32767, -32768, 1234, 0, -32768, 32767, -1),
            1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_INVERT, 23, -32768, 32767, -1, 0, 0, 0, 0), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_INVERT, 8, 1, 2, 3, 0, 0, 0, 0), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_VECTOR, 19, 0, 0, 0, 0, 1, -1, 32767), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_COMPOSE, 3, -5, 6, -7, 20, 8, -9, 10), 1'b0, no_res);
    add_row(make_req(crgi_pkg::OP_POINT, 10, -32768, -32768, -32768, 0, 32767, -32768,
                     32767), 1'b0, no_res);

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res,
                $urandom_range(0, MAX_GAP), 1'b0);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ((i >= 200 && i < 400) || (i >= 900 && i < 1000)) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      send_item(rand_req(), 1'b0, no_res, gap, (i == 0 || i == 700));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transfers (%0d directed), checked %0d results.",
             items_sent, directed_rows.size(), results_seen);
    $display("Saw %0d index errors, %0d saturated results, %0d stalled input cycles.",
             index_errs, saturations, stalled_cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
